// ===== rtl/signed_divider_remainder_defines.svh =====
// ----------------------------------------------------------------------------
// Signed divider assertion macros
// Shared property forms for the divider's checks, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DIVIDER_REMAINDER_DEFINES_SVH
`define SIGNED_DIVIDER_REMAINDER_DEFINES_SVH

// same-cycle implication
`define SDR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sdr_pkg.sv =====
// ----------------------------------------------------------------------------
// Signed divider package
// Widths and the control bundle passed from sequencer to datapath.
// ----------------------------------------------------------------------------
package sdr_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DATA_W);

  // one-cycle commands from the sequencer
  typedef struct packed {
    logic load;   // word accepted, capture operands
    logic step;   // one restoring division step
    logic fix;    // apply signs, register the result
  } sdr_ctrl_t;

endpackage

// ===== rtl/signed_divider_remainder.sv =====
// ----------------------------------------------------------------------------
// Signed 32-bit divider with remainder
// Quotient truncated toward zero and remainder with the dividend's sign.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Each word runs one
// restoring step per quotient bit through a single shared subtractor,
// then a sign fix step, and the result appears on the out_ ports with
// out_valid for exactly one cycle; the receiver cannot hold it off, so it
// must capture it then. A zero divisor gives quotient 0 and remainder
// equal to the dividend; the most negative dividend over -1 gives
// quotient 0x80000000 and remainder 0.
// ----------------------------------------------------------------------------
`include "signed_divider_remainder_defines.svh"

module signed_divider_remainder
  import sdr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] in_dividend,
  input  logic signed [DATA_W-1:0] in_divisor,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_quotient,
  output logic signed [DATA_W-1:0] out_remainder
);

  sdr_ctrl_t         ctrl;

  logic [DATA_W-1:0] num_r;     // dividend bits out, quotient bits in
  logic [DATA_W-1:0] den_r;
  logic [DATA_W-1:0] rem_r;
  logic              qneg_r;
  logic              rneg_r;
  logic              dzero_r;
  logic [DATA_W-1:0] quot_r;
  logic [DATA_W-1:0] remo_r;
  logic              out_valid_r;

  logic [DATA_W-1:0] a_mag;
  logic [DATA_W-1:0] b_mag;
  logic [DATA_W-1:0] rem_nxt;
  logic              qbit;

  sdr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  sdr_step u_step (
    .rem_i  (rem_r),
    .bit_i  (num_r[DATA_W-1]),
    .den_i  (den_r),
    .rem_o  (rem_nxt),
    .qbit_o (qbit)
  );

  // operand magnitudes, 2^31 stays as an unsigned value
  always_comb begin
    a_mag = in_dividend[DATA_W-1] ? DATA_W'(0) - DATA_W'(in_dividend) : DATA_W'(in_dividend);
    b_mag = in_divisor[DATA_W-1]  ? DATA_W'(0) - DATA_W'(in_divisor)  : DATA_W'(in_divisor);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      num_r   <= a_mag;
      den_r   <= b_mag;
      rem_r   <= '0;
      qneg_r  <= in_dividend[DATA_W-1] ^ in_divisor[DATA_W-1];
      rneg_r  <= in_dividend[DATA_W-1];
      dzero_r <= (in_divisor == '0);
    end else if (ctrl.step) begin
      num_r <= {num_r[DATA_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
    // with a zero divisor the remainder collects the dividend magnitude
    if (ctrl.fix) begin
      quot_r <= dzero_r ? '0 : (qneg_r ? DATA_W'(0) - num_r : num_r);
      remo_r <= rneg_r ? DATA_W'(0) - rem_r : rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.fix;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_quotient  = $signed(quot_r);
  assign out_remainder = $signed(remo_r);

  // checks
  `SDR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `SDR_ASSERT_SAME(a_valid_idle, out_valid, !busy, "result strobe while busy")
  `SDR_ASSERT_NEXT(a_valid_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `SDR_ASSERT_NEXT(a_fix_valid, ctrl.fix, out_valid, "sign fix not followed by result")

endmodule

// ===== rtl/sdr_step.sv =====
// ----------------------------------------------------------------------------
// Restoring division step
// Shifts one dividend bit into the partial remainder and subtracts the
// divisor magnitude when it fits, giving one quotient bit.
// ----------------------------------------------------------------------------
module sdr_step
  import sdr_pkg::*;
(
  input  logic [DATA_W-1:0] rem_i,
  input  logic              bit_i,
  input  logic [DATA_W-1:0] den_i,
  output logic [DATA_W-1:0] rem_o,
  output logic              qbit_o
);

  logic [DATA_W:0] shifted;
  logic [DATA_W:0] diff;

  // trial subtract on one extra bit, the comparison decides
  always_comb begin
    shifted = {rem_i, bit_i};
    diff    = shifted - {1'b0, den_i};
    qbit_o  = (shifted >= {1'b0, den_i});
    rem_o   = qbit_o ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
  end

endmodule

// ===== rtl/sdr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Signed divider sequencer
// Accepts a word, runs one division step per cycle for every quotient bit,
// then a sign fix step.
// ----------------------------------------------------------------------------
module sdr_ctrl
  import sdr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output sdr_ctrl_t ctrl
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIX  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign busy = (state_r != ST_IDLE);

  // commands decoded from state and start
  always_comb begin
    ctrl.load = (state_r == ST_IDLE) && start;
    ctrl.step = (state_r == ST_DIV);
    ctrl.fix  = (state_r == ST_FIX);
  end

  // next state and bit counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DIV;
          cnt_nxt   = CNT_W'(DATA_W - 1);
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== test/signed_divider_remainder_tb.sv =====
// ----------------------------------------------------------------------------
// Signed divider with remainder testbench
// Drives dividend/divisor words through the start/busy handshake. It predicts
// the truncated quotient and the wrapped remainder for every accepted word,
// and checks each strobed result against the oldest prediction. Covers the
// edge operands (zero divisor, most negative values, minus one), then
// randomized words with random sender gaps outside a middle stretch.
// ----------------------------------------------------------------------------
module signed_divider_remainder_tb
  import sdr_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 450;
  localparam int IDLE_PCT = 21;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t quotient;
    word_t remainder;
  } div_result_t;

  // Expected quotient/remainder store and checker
  class div_scoreboard;
    div_result_t pending_results[$];
    int err_count;
    int word_count;
    int zero_div_count;
    int neg_quot_count;

    function new();
      err_count = 0;
      word_count = 0;
      zero_div_count = 0;
      neg_quot_count = 0;
    endfunction

    // restoring division on magnitudes, sign fix, remainder in 32-bit wrap
    function div_result_t divide(word_t a, word_t b);
      word_t mag_a;
      word_t mag_b;
      word_t q;
      logic [DATA_W:0] part;
      div_result_t res;
      q = '0;
      if (b != '0) begin
        mag_a = a[DATA_W-1] ? -a : a;
        mag_b = b[DATA_W-1] ? -b : b;
        part = '0;
        for (int i = DATA_W - 1; i >= 0; i--) begin
          part = {part[DATA_W-1:0], mag_a[i]};
          if (part >= {1'b0, mag_b}) begin
            part = part - {1'b0, mag_b};
            q[i] = 1'b1;
          end
        end
        if (a[DATA_W-1] ^ b[DATA_W-1]) q = -q;
      end
      res.quotient = q;
      res.remainder = a - q * b;
      return res;
    endfunction

    function void note_operands(word_t a, word_t b);
      div_result_t res;
      res = divide(a, b);
      word_count++;
      if (b == '0) zero_div_count++;
      if (res.quotient[DATA_W-1]) neg_quot_count++;
      pending_results.push_back(res);
    endfunction

    function void check_result(word_t q, word_t r);
      div_result_t exp_res;
      if (pending_results.size() == 0) begin
        $error("unexpected result word: quotient %h remainder %h", q, r);
        err_count++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (q !== exp_res.quotient) begin
        $error("quotient: expected %h, actual %h", exp_res.quotient, q);
        err_count++;
      end
      if (r !== exp_res.remainder) begin
        $error("remainder: expected %h, actual %h", exp_res.remainder, r);
        err_count++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [DATA_W-1:0] in_dividend = '0;
  logic signed [DATA_W-1:0] in_divisor = '0;
  logic out_valid;
  logic signed [DATA_W-1:0] out_quotient;
  logic signed [DATA_W-1:0] out_remainder;

  int cycle_count = 0;
  div_scoreboard sb = new();

  signed_divider_remainder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_dividend  (in_dividend),
    .in_divisor   (in_divisor),
    .out_valid    (out_valid),
    .out_quotient (out_quotient),
    .out_remainder(out_remainder)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitor: results first, then the word taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_quotient, out_remainder);
      if (start && !busy) sb.note_operands(in_dividend, in_divisor);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one word and hold it until the divider takes it
  task automatic send_word(input word_t a, input word_t b);
    start <= 1'b1;
    in_dividend <= a;
    in_divisor <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start with junk on the operand ports; n sets the length of the gap
  task automatic idle_cycles(input int n);
    start <= 1'b0;
    in_dividend <= $urandom;
    in_divisor <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every predicted result has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mix of edge values, narrow magnitudes and full-range words
  function automatic word_t pick_operand();
    word_t v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'hffff_ffff;
          3: v = 32'h8000_0000;
          default: v = 32'h7fff_ffff;
        endcase
      end
      1, 2, 3: begin
        v = $urandom >> $urandom_range(DATA_W - 1);
        if ($urandom_range(1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  word_t dir_a[$] = '{
    32'd0,         32'd5,         32'hffff_fffb, 32'h8000_0000, 32'h8000_0000,
    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
    32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'd7,
    32'hffff_fff9, 32'd7,         32'hffff_fff9, 32'd1,         32'd0,
    32'd100,       32'hffff_ffff, 32'h7fff_ffff, 32'd3
  };
  word_t dir_b[$] = '{
    32'd0,         32'd0,         32'd0,         32'd0,         32'hffff_ffff,
    32'd1,         32'h8000_0000, 32'd2,         32'h7fff_ffff, 32'h8000_0000,
    32'd1,         32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'd2,
    32'd2,         32'hffff_fffe, 32'hffff_fffe, 32'h7fff_ffff, 32'hffff_fffb,
    32'd7,         32'd1,         32'h7fff_ffff, 32'd10
  };

  // Stimulus
  initial begin
    bit no_idle;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed edge cases, back to back
    foreach (dir_a[i]) send_word(dir_a[i], dir_b[i]);
    wait_drained();

    // random words; a middle stretch runs with no sender gaps
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      no_idle = (i >= 150 && i < 250);
      if (i == 300) wait_drained();
      if (!no_idle && $urandom_range(99) < IDLE_PCT) idle_cycles($urandom_range(1, 40));
      send_word(pick_operand(), pick_operand());
    end

    // drain and allow for any stray strobe
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d divisions: %0d by zero, %0d with a negative quotient",
             sb.word_count, sb.zero_div_count, sb.neg_quot_count);
    if (sb.err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== signed_divider_remainder.f =====
+incdir+rtl
rtl/sdr_pkg.sv
rtl/sdr_step.sv
rtl/sdr_ctrl.sv
rtl/signed_divider_remainder.sv
test/signed_divider_remainder_tb.sv
